### hw/rtl/msms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minutiae shift match package
// Shared types, command codes, register indexes and trial offsets.
// ----------------------------------------------------------------------------
package msms_pkg;

    localparam int DEF_MAX_PROBE     = 64;
    localparam int DEF_MAX_REFERENCE = 64;

    localparam int POS_W   = 12;
    localparam int ANG_W   = 9;
    localparam int BOX_W   = 8;
    localparam int STEP_W  = 8;
    localparam int LIMIT_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_CNT_W  = 7;
    localparam int SCORE_W    = 17;

    localparam int NUM_TRIALS = 9;

    localparam logic [BOX_W-1:0]   BOX_RESET   = 8'd10;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd15;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PROBE = 2'd1;
    localparam logic [1:0] CMD_REF   = 2'd2;
    localparam logic [1:0] CMD_MATCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_RANGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ANG_W-1:0] a;
    } minutia_t;

    typedef struct packed {
        logic     valid;
        logic     first;
        logic     last;
        minutia_t probe;
        minutia_t refm;
    } pair_t;

    typedef struct packed {
        logic [BOX_W-1:0]   box_range;
        logic [STEP_W-1:0]  shift_step;
        logic [LIMIT_W-1:0] angle_limit;
    } cfg_t;

    // Offset direction per trial: -1, 0 or +1 times the shift step.
    function automatic int trial_dx(input int t);
        unique case (t)
            1, 2, 8: trial_dx = 1;
            4, 5, 6: trial_dx = -1;
            default: trial_dx = 0;
        endcase
    endfunction

    function automatic int trial_dy(input int t);
        unique case (t)
            2, 3, 4: trial_dy = 1;
            6, 7, 8: trial_dy = -1;
            default: trial_dy = 0;
        endcase
    endfunction

endpackage

### hw/rtl/msms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minutiae shift match cell
// Tests one probe/reference pair at a fixed offset, counts paired probes and
// hands the pair on to the next cell.
// ----------------------------------------------------------------------------
module msms_cell #(
    parameter int DX = 0,
    parameter int DY = 0,
    parameter int CW = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  msms_pkg::cfg_t   cfg,
    input  msms_pkg::pair_t  pair_i,
    output msms_pkg::pair_t  pair_o,
    output logic [CW-1:0]    count_o
);
    import msms_pkg::*;

    localparam int DW = POS_W + 2;

    pair_t         pair_reg;
    logic          hit_reg;
    logic          hit_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic signed [STEP_W:0] dx;
    logic signed [STEP_W:0] dy;
    logic signed [DW-1:0]   ddx;
    logic signed [DW-1:0]   ddy;
    logic        [DW-1:0]   adx;
    logic        [DW-1:0]   ady;
    logic signed [ANG_W:0]  dang;
    logic        [ANG_W:0]  aang;
    logic                   match;

    always_comb begin
        dx = (DX > 0) ? $signed({1'b0, cfg.shift_step}) :
             (DX < 0) ? -$signed({1'b0, cfg.shift_step}) : '0;
        dy = (DY > 0) ? $signed({1'b0, cfg.shift_step}) :
             (DY < 0) ? -$signed({1'b0, cfg.shift_step}) : '0;
        // Reference minus shifted probe, compared against the window half width.
        ddx = $signed({2'b00, pair_i.refm.x}) - $signed({2'b00, pair_i.probe.x})
              - $signed({{(DW-STEP_W-1){dx[STEP_W]}}, dx});
        ddy = $signed({2'b00, pair_i.refm.y}) - $signed({2'b00, pair_i.probe.y})
              - $signed({{(DW-STEP_W-1){dy[STEP_W]}}, dy});
        adx = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
        ady = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
        dang = $signed({1'b0, pair_i.probe.a}) - $signed({1'b0, pair_i.refm.a});
        aang = dang[ANG_W] ? (ANG_W+1)'(-dang) : (ANG_W+1)'(dang);
        match = (adx <= DW'(cfg.box_range)) && (ady <= DW'(cfg.box_range)) &&
                (aang < {1'b0, cfg.angle_limit});
        hit_next = (pair_i.first ? 1'b0 : hit_reg) | match;
        count_next = count_reg;
        if (pair_i.last && hit_next) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        pair_reg.first <= pair_i.first;
        pair_reg.last  <= pair_i.last;
        pair_reg.probe <= pair_i.probe;
        pair_reg.refm  <= pair_i.refm;
        if (pair_i.valid) begin
            hit_reg <= hit_next;
        end
        if (!aresetn) begin
            pair_reg.valid <= 1'b0;
            count_reg      <= '0;
        end else begin
            pair_reg.valid <= pair_i.valid;
            if (clr) begin
                count_reg <= '0;
            end else if (pair_i.valid) begin
                count_reg <= count_next;
            end
        end
    end

    assign pair_o  = pair_reg;
    assign count_o = count_reg;

endmodule

### hw/rtl/msms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minutiae shift match divider
// Restoring divider, one quotient bit per cycle, for count * 2^16 / total.
// ----------------------------------------------------------------------------
module msms_div #(
    parameter int CW = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [CW-1:0]                  numer,
    input  logic [CW-1:0]                  denom,
    output logic [msms_pkg::SCORE_W-1:0]   quot,
    output logic                           done
);
    import msms_pkg::*;

    localparam int SW = $clog2(SCORE_W + 1);

    logic [CW-1:0]      rem_reg;
    logic               bit_reg;
    logic [SCORE_W-1:0] quot_reg;
    logic [SW-1:0]      steps_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CW:0]        trial;
    logic               ge;
    logic [CW-1:0]      rem_next;

    always_comb begin
        trial    = {rem_reg, bit_reg};
        ge       = trial >= {1'b0, denom};
        rem_next = ge ? CW'(trial - {1'b0, denom}) : CW'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (steps_reg == '0);
            if (start) begin
                busy_reg  <= 1'b1;
                steps_reg <= SW'(SCORE_W - 1);
            end else if (busy_reg) begin
                steps_reg <= steps_reg - SW'(1);
                if (steps_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The bits of the dividend above bit 16 leave numer >> 1 as remainder,
    // because the numerator never exceeds the denominator.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= numer >> 1;
            bit_reg  <= numer[0];
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            bit_reg  <= 1'b0;
            quot_reg <= {quot_reg[SCORE_W-2:0], ge};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

### hw/rtl/minutiae_shift_match_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minutiae shift match score
// Translation search over nine offsets between stored probe and reference
// minutiae, reporting the best paired count and its ratio to the probe total.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ channel. Clear, add-probe and add-reference commands
// are taken one per cycle while the block is idle and produce no result. A
// match command produces one item on the m_ channel. The match walks every
// probe/reference pair once, limited by the single read port of each store.
// The pairs stream through a row of nine cells, one per offset, then the
// nine counts are scanned, and a bit-serial divider forms the score. The block
// takes no item until the match result is loaded into the output register.
// The result stays in an output register until taken, and load commands are
// accepted meanwhile; the result of a following match waits for it to drain.
// Reset empties both sets, clears the overflow flag and restores the
// registers to box_range 10, shift_step 5 and angle_limit 15. Store contents
// need no clearing, because only entries below the counts are ever read.
// ----------------------------------------------------------------------------
module minutiae_shift_match_score #(
    parameter int MAX_PROBE     = msms_pkg::DEF_MAX_PROBE,
    parameter int MAX_REFERENCE = msms_pkg::DEF_MAX_REFERENCE
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [msms_pkg::POS_W-1:0]        s_pos_x,
    input  logic [msms_pkg::POS_W-1:0]        s_pos_y,
    input  logic [msms_pkg::ANG_W-1:0]        s_angle,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [msms_pkg::OUT_CNT_W-1:0]    m_best_count,
    output logic [msms_pkg::OUT_CNT_W-1:0]    m_probe_total,
    output logic [msms_pkg::SCORE_W-1:0]      m_score,
    output logic                              m_empty_probe,
    output logic                              m_overflowed,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import msms_pkg::*;

    localparam int PCW = $clog2(MAX_PROBE + 1);
    localparam int RCW = $clog2(MAX_REFERENCE + 1);
    localparam int PAW = (MAX_PROBE > 1) ? $clog2(MAX_PROBE) : 1;
    localparam int RAW = (MAX_REFERENCE > 1) ? $clog2(MAX_REFERENCE) : 1;
    localparam int DRW = $clog2(NUM_TRIALS + 1);
    localparam int SIW = $clog2(NUM_TRIALS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_WALK, ST_DRAIN, ST_SCAN, ST_DIV, ST_DONE
    } state_t;

    state_t         state_reg;
    cfg_t           cfg_reg;
    logic [PCW-1:0] probe_count_reg;
    logic [RCW-1:0] ref_count_reg;
    logic           overflow_reg;

    // Walk pointers over the probe and reference stores.
    logic [PCW-1:0] pj_reg;
    logic [RCW-1:0] rk_reg;
    logic [DRW-1:0] drain_reg;
    logic [SIW-1:0] scan_reg;
    logic [PCW-1:0] best_reg;
    logic           div_start_reg;

    logic                  m_valid_reg;
    logic [OUT_CNT_W-1:0]  m_best_reg;
    logic [OUT_CNT_W-1:0]  m_total_reg;
    logic [SCORE_W-1:0]    m_score_reg;
    logic                  m_empty_reg;
    logic                  m_ovf_reg;

    // Stores and their registered read stage.
    minutia_t probe_mem [0:MAX_PROBE-1];
    minutia_t ref_mem   [0:MAX_REFERENCE-1];
    minutia_t probe_q_reg;
    minutia_t ref_q_reg;
    logic     rd_valid_reg;
    logic     rd_first_reg;
    logic     rd_last_reg;

    pair_t          chain [0:NUM_TRIALS];
    logic [PCW-1:0] counts [0:NUM_TRIALS-1];

    logic                s_accept;
    logic                match_start;
    logic                last_ref;
    logic                last_probe;
    logic                out_free;
    logic [SCORE_W-1:0]  div_quot;
    logic                div_done;
    minutia_t            in_minutia;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign match_start = s_accept && (s_command == CMD_MATCH);
    assign cfg_ready   = 1'b1;
    assign last_ref    = (rk_reg + RCW'(1)) == ref_count_reg;
    assign last_probe  = (pj_reg + PCW'(1)) == probe_count_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign in_minutia  = '{x: s_pos_x, y: s_pos_y, a: s_angle};

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_range   <= BOX_RESET;
            cfg_reg.shift_step  <= STEP_RESET;
            cfg_reg.angle_limit <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BOX_RANGE:   cfg_reg.box_range   <= cfg_data[BOX_W-1:0];
                REG_SHIFT_STEP:  cfg_reg.shift_step  <= cfg_data[STEP_W-1:0];
                REG_ANGLE_LIMIT: cfg_reg.angle_limit <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Store writes on loads that fit; reads feed the cell row during a walk.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_command == CMD_PROBE) &&
            (probe_count_reg != PCW'(MAX_PROBE))) begin
            probe_mem[probe_count_reg[PAW-1:0]] <= in_minutia;
        end
        if (s_accept && (s_command == CMD_REF) &&
            (ref_count_reg != RCW'(MAX_REFERENCE))) begin
            ref_mem[ref_count_reg[RAW-1:0]] <= in_minutia;
        end
        probe_q_reg  <= probe_mem[pj_reg[PAW-1:0]];
        ref_q_reg    <= ref_mem[rk_reg[RAW-1:0]];
        rd_first_reg <= (rk_reg == '0);
        rd_last_reg  <= last_ref;
    end

    // Main sequencer: counts, walk, drain, scan, divide and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            probe_count_reg <= '0;
            ref_count_reg   <= '0;
            overflow_reg    <= 1'b0;
            rd_valid_reg    <= 1'b0;
            div_start_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            rd_valid_reg  <= (state_reg == ST_WALK);
            div_start_reg <= (state_reg == ST_SCAN) && (scan_reg == SIW'(NUM_TRIALS - 1));
            // A result leaving while a new one is loaded is handled in ST_DONE.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        unique case (s_command)
                            CMD_CLEAR: begin
                                probe_count_reg <= '0;
                                ref_count_reg   <= '0;
                                overflow_reg    <= 1'b0;
                            end
                            CMD_PROBE: begin
                                if (probe_count_reg != PCW'(MAX_PROBE)) begin
                                    probe_count_reg <= probe_count_reg + PCW'(1);
                                end else begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            CMD_REF: begin
                                if (ref_count_reg != RCW'(MAX_REFERENCE)) begin
                                    ref_count_reg <= ref_count_reg + RCW'(1);
                                end else begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            CMD_MATCH: begin
                                pj_reg    <= '0;
                                rk_reg    <= '0;
                                drain_reg <= '0;
                                if ((probe_count_reg == '0) || (ref_count_reg == '0)) begin
                                    state_reg <= ST_DRAIN;
                                end else begin
                                    state_reg <= ST_WALK;
                                end
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    if (last_ref) begin
                        rk_reg <= '0;
                        if (last_probe) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            pj_reg <= pj_reg + PCW'(1);
                        end
                    end else begin
                        rk_reg <= rk_reg + RCW'(1);
                    end
                end
                ST_DRAIN: begin
                    // Let the last pair ripple through every cell.
                    drain_reg <= drain_reg + DRW'(1);
                    if (drain_reg == DRW'(NUM_TRIALS)) begin
                        state_reg <= ST_SCAN;
                        scan_reg  <= '0;
                        best_reg  <= '0;
                    end
                end
                ST_SCAN: begin
                    if (counts[scan_reg] > best_reg) begin
                        best_reg <= counts[scan_reg];
                    end
                    scan_reg <= scan_reg + SIW'(1);
                    if (scan_reg == SIW'(NUM_TRIALS - 1)) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_best_reg  <= OUT_CNT_W'(best_reg);
                        m_total_reg <= OUT_CNT_W'(probe_count_reg);
                        m_empty_reg <= (probe_count_reg == '0);
                        m_ovf_reg   <= overflow_reg;
                        m_score_reg <= (probe_count_reg == '0) ? '0 : div_quot;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Head of the cell row: the pair read from the stores last cycle.
    assign chain[0] = '{valid: rd_valid_reg, first: rd_first_reg, last: rd_last_reg,
                        probe: probe_q_reg, refm: ref_q_reg};

    for (genvar t = 0; t < NUM_TRIALS; t++) begin : g_cell
        msms_cell #(
            .DX(trial_dx(t)),
            .DY(trial_dy(t)),
            .CW(PCW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clr     (match_start),
            .cfg     (cfg_reg),
            .pair_i  (chain[t]),
            .pair_o  (chain[t+1]),
            .count_o (counts[t])
        );
    end

    msms_div #(
        .CW(PCW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .numer   (best_reg),
        .denom   (probe_count_reg),
        .quot    (div_quot),
        .done    (div_done)
    );

    assign m_valid       = m_valid_reg;
    assign m_best_count  = m_best_reg;
    assign m_probe_total = m_total_reg;
    assign m_score       = m_score_reg;
    assign m_empty_probe = m_empty_reg;
    assign m_overflowed  = m_ovf_reg;

    // A probe load into a full store must raise the overflow flag.
    a_probe_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_command == CMD_PROBE) && (probe_count_reg == PCW'(MAX_PROBE)))
        |=> overflow_reg)
        else $error("probe overflow not flagged");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // The best count never exceeds the number of probes.
    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (best_reg <= probe_count_reg))
        else $error("best count above probe total");

    // An empty probe set gives a zero score.
    a_empty_score: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_score_reg == '0))
        else $error("nonzero score for empty probe set");

endmodule

### test/tb_minutiae_shift_match_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minutiae shift match score testbench
// Loads probe and reference minutiae, runs match commands under several
// register settings and compares every match item on the m_ channel with an
// in-bench model of the nine-offset translation search. Both channels idle
// at random, the receiver holds off once for a long stretch, and a few
// sessions fill both stores past capacity.
// ----------------------------------------------------------------------------
module tb_minutiae_shift_match_score;
    import msms_pkg::*;

    // The receiver hold-off is long enough to leave a result in the output
    // register while later loads and the next match pile up behind it.
    localparam int HOLD_CYCLES   = 600;
    // Loads and clears take effect as they are taken, so this covers any late work
    // before a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 180;
    localparam int NUM_PHASES    = 6;

    // Offset direction of each trial, in units of the shift step.
    localparam int SHIFT_DX [NUM_TRIALS] = '{0, 1, 1, 0, -1, -1, -1, 0, 1};
    localparam int SHIFT_DY [NUM_TRIALS] = '{0, 0, 1, 1, 1, 0, -1, -1, -1};

    typedef struct packed {
        logic [1:0] command;
        minutia_t   m;
    } cmd_item_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] best_count;
        logic [OUT_CNT_W-1:0] probe_total;
        logic [SCORE_W-1:0]   score;
        logic                 empty_probe;
        logic                 overflowed;
    } match_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_command = CMD_CLEAR;
    logic [POS_W-1:0]      s_pos_x   = '0;
    logic [POS_W-1:0]      s_pos_y   = '0;
    logic [ANG_W-1:0]      s_angle   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [OUT_CNT_W-1:0]  m_best_count;
    logic [OUT_CNT_W-1:0]  m_probe_total;
    logic [SCORE_W-1:0]    m_score;
    logic                  m_empty_probe;
    logic                  m_overflowed;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BOX_RANGE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Items waiting for the driver, and match results still owed by the block.
    cmd_item_t     pending_items [$];
    match_result_t expected_results [$];
    cmd_item_t     drive_item;

    int pushed_count    = 0;
    int accepted_count  = 0;
    int fail_count      = 0;
    bit no_idle         = 1'b0;
    int holds_requested = 0;
    int holds_done      = 0;
    int hold_left       = 0;

    // Model copy of the block's stores, counters and registers.
    minutia_t           probe_mem [DEF_MAX_PROBE];
    minutia_t           ref_mem [DEF_MAX_REFERENCE];
    int                 probe_cnt     = 0;
    int                 ref_cnt       = 0;
    bit                 overflow_seen = 1'b0;
    logic [BOX_W-1:0]   box_range_q   = BOX_RESET;
    logic [STEP_W-1:0]  shift_step_q  = STEP_RESET;
    logic [LIMIT_W-1:0] angle_limit_q = LIMIT_RESET;

    minutiae_shift_match_score i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_angle       (s_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_count  (m_best_count),
        .m_probe_total (m_probe_total),
        .m_score       (m_score),
        .m_empty_probe (m_empty_probe),
        .m_overflowed  (m_overflowed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // A shifted probe pairs with a reference when both coordinates fall in
    // the inclusive box and the plain angle difference is below the limit.
    // Everything is widened to signed int first, so shifted positions may
    // go below zero or past the top of the coordinate range.
    function automatic bit minutiae_pair(minutia_t p, minutia_t r, int dx, int dy);
        int px, py, rx, ry, pa, ra, da, box, lim;
        px  = p.x;
        py  = p.y;
        rx  = r.x;
        ry  = r.y;
        pa  = p.a;
        ra  = r.a;
        box = box_range_q;
        lim = angle_limit_q;
        px  = px + dx;
        py  = py + dy;
        da  = (pa > ra) ? pa - ra : ra - pa;
        return rx >= px - box && rx <= px + box &&
               ry >= py - box && ry <= py + box && da < lim;
    endfunction

    // Best paired count over the nine offsets and its floored Q1.16 ratio.
    function automatic match_result_t search_offsets();
        match_result_t res;
        int best, hits, step;
        best = 0;
        step = shift_step_q;
        for (int t = 0; t < NUM_TRIALS; t++) begin
            hits = 0;
            for (int j = 0; j < probe_cnt; j++) begin
                for (int k = 0; k < ref_cnt; k++) begin
                    if (minutiae_pair(probe_mem[j], ref_mem[k],
                                      SHIFT_DX[t] * step, SHIFT_DY[t] * step)) begin
                        hits++;
                        break;
                    end
                end
            end
            if (hits > best) begin
                best = hits;
            end
        end
        res.best_count  = OUT_CNT_W'(best);
        res.probe_total = OUT_CNT_W'(probe_cnt);
        res.score       = (probe_cnt == 0) ? '0 : SCORE_W'((best << 16) / probe_cnt);
        res.empty_probe = (probe_cnt == 0);
        res.overflowed  = overflow_seen;
        return res;
    endfunction

    // Update the model for one accepted item; a match owes one result.
    function automatic void take_item(cmd_item_t it);
        case (it.command)
            CMD_CLEAR: begin
                probe_cnt     = 0;
                ref_cnt       = 0;
                overflow_seen = 1'b0;
            end
            CMD_PROBE: begin
                if (probe_cnt < DEF_MAX_PROBE) begin
                    probe_mem[probe_cnt] = it.m;
                    probe_cnt++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            CMD_REF: begin
                if (ref_cnt < DEF_MAX_REFERENCE) begin
                    ref_mem[ref_cnt] = it.m;
                    ref_cnt++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            default: begin
                expected_results.push_back(search_offsets());
            end
        endcase
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        match_result_t want;
        if (expected_results.size() == 0) begin
            $error("match result with none outstanding: best_count %0d, score %0d",
                   m_best_count, m_score);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("best_count", want.best_count, m_best_count);
        compare_field("probe_total", want.probe_total, m_probe_total);
        compare_field("score", want.score, m_score);
        compare_field("empty_probe", want.empty_probe, m_empty_probe);
        compare_field("overflowed", want.overflowed, m_overflowed);
    endfunction

    // Driver: offers the next queued item once the current one is taken,
    // idling about a third of the time unless a no-idle stretch is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
                drive_item = pending_items.pop_front();
                s_valid   <= 1'b1;
                s_command <= drive_item.command;
                s_pos_x   <= drive_item.m.x;
                s_pos_y   <= drive_item.m.y;
                s_angle   <= drive_item.m.a;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here when the
    // stimulus asks for it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done < holds_requested) begin
            m_ready    <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
        end else begin
            m_ready <= no_idle || $urandom_range(99) >= 33;
        end
    end

    // Monitor: register writes and input items feed the model at the edge
    // they are taken; results are checked at the edge they are taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BOX_RANGE:   box_range_q   = cfg_data[BOX_W-1:0];
                    REG_SHIFT_STEP:  shift_step_q  = cfg_data[STEP_W-1:0];
                    REG_ANGLE_LIMIT: angle_limit_q = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                take_item('{s_command, '{s_pos_x, s_pos_y, s_angle}});
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                check_result();
            end
        end
    end

    task automatic push_item(logic [1:0] cmd, int x, int y, int a);
        cmd_item_t it;
        it.command = cmd;
        it.m.x     = x[POS_W-1:0];
        it.m.y     = y[POS_W-1:0];
        it.m.a     = a[ANG_W-1:0];
        pending_items.push_back(it);
        pushed_count++;
    endtask

    // Mostly in-range angles, sometimes raw values above 359.
    function automatic int random_angle();
        return ($urandom_range(9) == 0) ? $urandom_range(360, 511) : $urandom_range(359);
    endfunction

    function automatic int random_coord();
        if ($urandom_range(3) != 0) begin
            return $urandom_range(4095);
        end
        return $urandom_range(1) ? $urandom_range(15) : 4095 - $urandom_range(15);
    endfunction

    // Waits until every queued item is taken and every result has come.
    task automatic wait_drained();
        while (accepted_count != pushed_count || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes all three registers back to back. Bit 8 of the data is random
    // for the 8-bit registers, since the block keeps only the low bits.
    task automatic write_registers(int box, int step, int limit);
        logic [CFG_IDX_W-1:0]  regs [3] = '{REG_BOX_RANGE, REG_SHIFT_STEP, REG_ANGLE_LIMIT};
        logic [CFG_DATA_W-1:0] vals [3];
        vals[0] = CFG_DATA_W'(box);
        vals[1] = CFG_DATA_W'(step);
        vals[2] = CFG_DATA_W'(limit);
        for (int i = 0; i < 3; i++) begin
            if (regs[i] != REG_ANGLE_LIMIT) begin
                vals[i][BOX_W] = 1'($urandom_range(1));
            end
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // One matching session: an optional clear, probes clustered around a
    // random spot (often at the coordinate edges), references mostly built
    // from a probe moved by one of the nine offsets plus jitter just around
    // the box and the angle limit, then one or more matches. A little noise
    // of random commands is mixed in.
    task automatic queue_session(int n_probe, int n_ref, int n_match, bit with_clear);
        logic [1:0] any_cmd [4] = '{CMD_CLEAR, CMD_PROBE, CMD_REF, CMD_MATCH};
        minutia_t   probes [$];
        minutia_t   m;
        int cx, cy, p_left, r_left, pick, span, alim, step;
        cx   = random_coord();
        cy   = random_coord();
        span = int'(box_range_q) + 2;
        alim = int'(angle_limit_q) + 1;
        step = shift_step_q;
        for (int i = 0; i < n_probe; i++) begin
            m.x = POS_W'(cx + $urandom_range(40));
            m.y = POS_W'(cy + $urandom_range(40));
            m.a = ANG_W'(random_angle());
            probes.push_back(m);
        end
        if (with_clear) begin
            push_item(CMD_CLEAR, $urandom_range(4095), $urandom_range(4095), $urandom_range(511));
        end
        p_left = n_probe;
        r_left = n_ref;
        while (p_left + r_left > 0) begin
            if (r_left == 0 || (p_left != 0 && $urandom_range(1) == 1)) begin
                m = probes[n_probe - p_left];
                p_left--;
                push_item(CMD_PROBE, m.x, m.y, m.a);
            end else begin
                r_left--;
                if (n_probe != 0 && $urandom_range(9) < 7) begin
                    m    = probes[$urandom_range(n_probe - 1)];
                    pick = $urandom_range(NUM_TRIALS - 1);
                    m.x  = POS_W'(int'(m.x) + SHIFT_DX[pick] * step
                                  + int'($urandom_range(2 * span)) - span);
                    m.y  = POS_W'(int'(m.y) + SHIFT_DY[pick] * step
                                  + int'($urandom_range(2 * span)) - span);
                    m.a  = ANG_W'(int'(m.a) + int'($urandom_range(2 * alim)) - alim);
                end else begin
                    m.x = POS_W'(random_coord());
                    m.y = POS_W'(random_coord());
                    m.a = ANG_W'(random_angle());
                end
                push_item(CMD_REF, m.x, m.y, m.a);
            end
            if ($urandom_range(24) == 0) begin
                push_item(any_cmd[$urandom_range(3)], $urandom_range(4095),
                          $urandom_range(4095), random_angle());
            end
        end
        for (int i = 0; i < n_match; i++) begin
            push_item(CMD_MATCH, $urandom_range(4095), $urandom_range(4095), $urandom_range(511));
            if ($urandom_range(3) == 0) begin
                push_item(any_cmd[$urandom_range(1, 2)], random_coord(), random_coord(),
                          random_angle());
            end
        end
    endtask

    initial begin
        int phase_start, n_p, n_r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset register values: both sets empty,
        // probes and references at the coordinate extremes, a pair found
        // only through a diagonal offset, angles that would pair if the
        // difference wrapped around 360 but must not, an empty reference
        // set, and an empty probe set with references present.
        push_item(CMD_MATCH, 0, 0, 0);
        push_item(CMD_PROBE, 0, 0, 0);
        push_item(CMD_PROBE, 4095, 4095, 511);
        push_item(CMD_REF, 0, 0, 14);
        push_item(CMD_REF, 4090, 4095, 500);
        push_item(CMD_MATCH, 4095, 4095, 511);
        push_item(CMD_PROBE, 2048, 2048, 180);
        push_item(CMD_REF, 2059, 2059, 194);
        push_item(CMD_PROBE, 300, 300, 1);
        push_item(CMD_REF, 300, 300, 359);
        push_item(CMD_MATCH, 0, 0, 0);
        push_item(CMD_CLEAR, 4095, 4095, 511);
        push_item(CMD_MATCH, 0, 0, 0);
        push_item(CMD_PROBE, 100, 200, 45);
        push_item(CMD_MATCH, 0, 0, 0);
        push_item(CMD_CLEAR, 0, 0, 0);
        push_item(CMD_REF, 7, 7, 7);
        push_item(CMD_MATCH, 0, 0, 0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Registers change only with the block idle; phase 0 keeps the
            // reset values.
            case (phase)
                1: write_registers(0, 0, 0);
                2: write_registers(255, 255, 359);
                3: write_registers(BOX_RESET, STEP_RESET, LIMIT_RESET);
                4: write_registers(255, 0, 511);
                5: write_registers($urandom_range(1, 40), $urandom_range(1, 30),
                                   $urandom_range(1, 400));
                default: ;
            endcase
            no_idle = (phase == 2);
            if (phase == 3) begin
                holds_requested++;
            end
            phase_start = pushed_count;
            // Both stores filled past capacity so loads are dropped and the
            // overflow flag shows in the results.
            if (phase == 0 || phase == 5) begin
                queue_session(DEF_MAX_PROBE + 2, DEF_MAX_REFERENCE + 2, 2, 1'b1);
            end
            while (pushed_count - phase_start < PHASE_ITEMS) begin
                n_p = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
                n_r = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
                queue_session(n_p, n_r, $urandom_range(1, 3), $urandom_range(6) != 0);
            end
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### minutiae_shift_match_score.f
hw/rtl/msms_pkg.sv
hw/rtl/msms_cell.sv
hw/rtl/msms_div.sv
hw/rtl/minutiae_shift_match_score.sv
test/tb_minutiae_shift_match_score.sv
